// ----- hdl/assert_macros.svh -----
// Shared assertion macros for the sorted list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock edge and muted during reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but the property is also required to hold while reset is high.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/slist_pkg.sv -----
package slist_pkg;

   // Number of cells in the chain.
   localparam int CAPACITY = 16;

   localparam int VALUE_W     = 32;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Operation codes on the mode field.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // Status codes on the result channel.
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                       insert_en;
      logic                       delete_en;
      logic signed [VALUE_W-1:0]  op_value;
   } cell_ctrl_type;

endpackage

// ----- hdl/slist_if.sv -----
// Request channel: operation and value.
interface slist_req_if;
   import slist_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

// Response channel: status and count after the operation.
interface slist_rsp_if;
   import slist_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [COUNT_OUT_W-1:0] count;

   modport source (output valid, output status, output count, input ready);
   modport sink   (input valid, input status, input count, output ready);
endinterface

// ----- hdl/slist_cell.sv -----
// One slot of the sorted chain. It compares its value with the broadcast
// operand and, on an update, keeps its value, takes the operand, or takes
// the value of a neighbor.
module slist_cell (
   input  logic                               clock,
   input  slist_pkg::cell_ctrl_type           ctrl,
   input  logic                               slot_valid,
   input  logic signed [slist_pkg::VALUE_W-1:0] prev_value,
   input  logic                               prev_lt,
   input  logic signed [slist_pkg::VALUE_W-1:0] next_value,
   output logic signed [slist_pkg::VALUE_W-1:0] value,
   output logic                               lt,
   output logic                               eq
);
   import slist_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // Compare flags; an empty slot counts as not smaller and not equal.
   assign lt    = slot_valid && (value_ff < ctrl.op_value);
   assign eq    = slot_valid && (value_ff == ctrl.op_value);
   assign value = value_ff;

   // Slots from the insert point on move up by one; the insert point takes
   // the operand. On a delete step, slots from the first match on move down.
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert_en && !lt) begin
         value_in = prev_lt ? ctrl.op_value : prev_value;
      end else if (ctrl.delete_en && !lt) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- hdl/sorted_list_insert_delete.sv -----
// Sorted list of up to CAPACITY signed 32-bit values held in a chain of cells,
// one value per cell in ascending order. One request is in work at a time.
// An insert registers the request, then shifts the chain, places the value and
// loads the result register. A delete registers the request, then removes one
// copy per cycle as the chain closes the gap by one slot, and loads the result
// register once no copy is left; a delete that finds nothing answers with
// status not found. An insert into a full list is dropped with status full. A
// new request is taken once the result register is empty or is being read in
// the same cycle.
module sorted_list_insert_delete (
   input  logic        clock,
   input  logic        reset,
   slist_req_if.sink   req_bus,
   slist_rsp_if.source rsp_bus
);
   import slist_pkg::*;
   `include "assert_macros.svh"

   state_type                 state_ff, state_in;
   logic                      op_mode_ff, op_mode_in;
   logic signed [VALUE_W-1:0] op_value_ff, op_value_in;
   logic                      found_ff, found_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;

   cell_ctrl_type             ctrl;
   logic signed [VALUE_W-1:0] values [CAPACITY];
   logic [CAPACITY-1:0]       lt_vec;
   logic [CAPACITY-1:0]       eq_vec;
   logic [CAPACITY-1:0]       valid_vec;
   logic                      full;
   logic                      any_eq;
   logic                      req_beat;

   assign full     = count_ff >= CNT_W'(CAPACITY);
   assign any_eq   = |eq_vec;
   assign req_beat = req_bus.valid && req_bus.ready;

   assign req_bus.ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.count  = rsp_count_ff;

   // The chain of cells; each cell sees its neighbors' values.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_v;
      logic signed [VALUE_W-1:0] next_v;
      logic                      prev_l;

      assign valid_vec[i] = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_head
         assign prev_v = values[i];
         assign prev_l = 1'b1;
      end else begin : g_body
         assign prev_v = values[i-1];
         assign prev_l = lt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_v = values[i];
      end else begin : g_inner
         assign next_v = values[i+1];
      end

      slist_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .slot_valid (valid_vec[i]),
         .prev_value (prev_v),
         .prev_lt    (prev_l),
         .next_value (next_v),
         .value      (values[i]),
         .lt         (lt_vec[i]),
         .eq         (eq_vec[i])
      );
   end

   // Controller: register the request, then insert once unless the list is full,
   // or delete one copy per cycle until no copy is left, then load the result register.
   always_comb begin
      state_in       = state_ff;
      op_mode_in     = op_mode_ff;
      op_value_in    = op_value_ff;
      found_in       = found_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      ctrl.insert_en = 1'b0;
      ctrl.delete_en = 1'b0;
      ctrl.op_value  = op_value_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_mode_in  = req_bus.mode;
               op_value_in = req_bus.value;
               found_in    = 1'b0;
               state_in    = S_BUSY;
            end
         end
         S_BUSY: begin
            if (op_mode_ff == MODE_INSERT) begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctrl.insert_en = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
                  rsp_status_in  = ST_DONE;
               end
               rsp_valid_in = 1'b1;
               rsp_count_in = COUNT_OUT_W'(count_in);
               state_in     = S_IDLE;
            end else if (any_eq) begin
               ctrl.delete_en = 1'b1;
               count_in       = count_ff - CNT_W'(1);
               found_in       = 1'b1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? ST_DONE : ST_MISSING;
               rsp_count_in  = COUNT_OUT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_mode_ff    <= op_mode_in;
      op_value_ff   <= op_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // The list never holds more values than it has cells.
   `ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CNT_W'(CAPACITY)), "count over capacity")
   // A request beat always starts the work state.
   `ASSERT_CLK(a_beat_busy, clock, reset, req_beat |=> (state_ff == S_BUSY), "beat did not start work")
   // The result register is empty while a request is in work.
   `ASSERT_CLK(a_busy_empty, clock, reset, (state_ff == S_BUSY) |-> !rsp_valid_ff, "result pending during work")
   // A delete step always removes exactly one value.
   `ASSERT_CLK(a_delete_step, clock, reset, ctrl.delete_en |=> (count_ff == $past(count_ff) - CNT_W'(1)), "delete step count")

endmodule
